### design/stfs_pkg.sv
// Shared constants, codes and controller/datapath interface types for the sorted table search.
`timescale 1ns / 1ps
`default_nettype none

package stfs_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FIB_W    = CNT_W + 1;   // Fibonacci terms stay below twice the count
    localparam int SUM_W    = FIB_W + 1;   // signed offset and probe sums

    // Fixed field widths
    localparam int IN_W      = 32;
    localparam int KEY_W     = 31;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = 7;
    localparam int ENT_W     = 8;
    localparam int IN_DATA_W = 2 * IN_W;
    localparam int OUT_W     = STATUS_W + POS_W + 2 * KEY_W + ENT_W;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_KEY   = 3'd2,
        ST_BAD_COST  = 3'd3,
        ST_FOUND     = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FIB,
        S_LOOP,
        S_PROBE_ADDR,
        S_PROBE_CMP,
        S_FINAL_ADDR,
        S_FINAL_CMP,
        S_SHIFT_ADDR,
        S_SHIFT_CMP,
        S_PLACE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load;       // take the input transfer
        logic    fib_step;   // grow the Fibonacci triple
        logic    probe_rd;   // read at the clamped probe index
        logic    probe_lt;   // probed key below target
        logic    probe_gt;   // probed key above target
        logic    final_rd;   // read at offset plus one
        logic    shift_rd;   // first read of the insert shift
        logic    shift;      // move one record up, read the next one down
        logic    place;      // write the new record, bump the count
        logic    finish;     // load the result register
        logic    res_found;  // result carries the hit record
        t_status res_code;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_search;
        logic full;
        logic key_bad;
        logic cost_neg;
        logic empty;
        logic fib_lt;
        logic f_gt1;
        logic key_eq;
        logic key_lt;
        logic rd_gt;
        logic at_zero;
        logic at_one;
        logic final_ok;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### design/sorted_table_fibonacci_search.sv
// Top level of the sorted record table with Fibonacci search.
//
// Holds up to 128 records (positive 31-bit key, non-negative 31-bit payload)
// in ascending key order, equal keys in arrival order. An insert transfer
// (tuser 0) moves every stored record with a larger key up by one place,
// one record per cycle through the record memory, then writes the new record.
// A search transfer (tuser 1) runs the Fibonacci setup steps (up to 10 at
// 128 records) and then the probes (up to 10), each probe one registered
// memory read and one compare. Refused items finish in the check state.
// One item is processed at a time; the input is taken again while the
// previous result still waits in the output register. The record memories
// need no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_fibonacci_search import stfs_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [IN_DATA_W-1:0] s_axis_tdata,   // key_id[31:0], payload_cost[63:32]
    input  wire                  s_axis_tuser,   // operation
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata    // status[2:0], sorted_position[9:3],
                                                 // found_key[40:10], found_cost[71:41],
                                                 // entries_held[79:72]
);

    t_cmd               cmd;
    t_sts               sts;
    logic [STATUS_W-1:0] res_status;
    logic [POS_W-1:0]    res_pos;
    logic [KEY_W-1:0]    res_key;
    logic [KEY_W-1:0]    res_cost;
    logic [ENT_W-1:0]    res_entries;

    // Sequencer
    stfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Storage and arithmetic
    stfs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_op     (s_axis_tuser),
        .i_in_key    (s_axis_tdata[IN_W-1:0]),
        .i_in_cost   (s_axis_tdata[IN_DATA_W-1:IN_W]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (res_status),
        .o_pos       (res_pos),
        .o_key       (res_key),
        .o_cost      (res_cost),
        .o_entries   (res_entries)
    );

    assign m_axis_tdata = {res_entries, res_cost, res_key, res_pos, res_status};

endmodule

`default_nettype wire

### design/stfs_ctrl.sv
// Controller state machine: sequences the checks, Fibonacci probes and insert shift.
`timescale 1ns / 1ps
`default_nettype none

module stfs_ctrl import stfs_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.is_search) begin
                    if (i_sts.key_bad || i_sts.empty) begin
                        if (i_sts.out_free) n_state = S_IDLE;
                    end else begin
                        n_state = S_FIB;
                    end
                end else begin
                    if (i_sts.full || i_sts.key_bad || i_sts.cost_neg) begin
                        if (i_sts.out_free) n_state = S_IDLE;
                    end else begin
                        n_state = S_SHIFT_ADDR;
                    end
                end
            end
            S_FIB: begin
                if (!i_sts.fib_lt) n_state = i_sts.f_gt1 ? S_PROBE_ADDR : S_FINAL_ADDR;
            end
            S_LOOP: begin
                n_state = i_sts.f_gt1 ? S_PROBE_ADDR : S_FINAL_ADDR;
            end
            S_PROBE_ADDR: begin
                n_state = S_PROBE_CMP;
            end
            S_PROBE_CMP: begin
                if (i_sts.key_eq) begin
                    if (i_sts.out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_FINAL_ADDR: begin
                if (i_sts.final_ok) begin
                    n_state = S_FINAL_CMP;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FINAL_CMP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_SHIFT_ADDR: begin
                if (!i_sts.at_zero) begin
                    n_state = S_SHIFT_CMP;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT_CMP: begin
                if (i_sts.rd_gt) begin
                    if (i_sts.at_one) n_state = S_PLACE;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_PLACE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands; every step that ends an item waits for a free result register
    always_comb begin
        o_cmd          = '0;
        o_cmd.res_code = ST_INSERTED;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.finish = i_sts.out_free;
                if (i_sts.is_search) begin
                    priority if (i_sts.key_bad) begin
                        o_cmd.res_code = ST_BAD_KEY;
                    end else if (i_sts.empty) begin
                        o_cmd.res_code = ST_EMPTY;
                    end else begin
                        o_cmd.finish = 1'b0;
                    end
                end else begin
                    priority if (i_sts.full) begin
                        o_cmd.res_code = ST_FULL;
                    end else if (i_sts.key_bad) begin
                        o_cmd.res_code = ST_BAD_KEY;
                    end else if (i_sts.cost_neg) begin
                        o_cmd.res_code = ST_BAD_COST;
                    end else begin
                        o_cmd.finish = 1'b0;
                    end
                end
            end
            S_FIB: begin
                o_cmd.fib_step = i_sts.fib_lt;
            end
            S_LOOP: begin
            end
            S_PROBE_ADDR: begin
                o_cmd.probe_rd = 1'b1;
            end
            S_PROBE_CMP: begin
                if (i_sts.key_eq) begin
                    o_cmd.finish    = i_sts.out_free;
                    o_cmd.res_found = 1'b1;
                    o_cmd.res_code  = ST_FOUND;
                end else if (i_sts.key_lt) begin
                    o_cmd.probe_lt = 1'b1;
                end else begin
                    o_cmd.probe_gt = 1'b1;
                end
            end
            S_FINAL_ADDR: begin
                if (i_sts.final_ok) begin
                    o_cmd.final_rd = 1'b1;
                end else begin
                    o_cmd.finish   = i_sts.out_free;
                    o_cmd.res_code = ST_NOT_FOUND;
                end
            end
            S_FINAL_CMP: begin
                o_cmd.finish    = i_sts.out_free;
                o_cmd.res_found = i_sts.key_eq;
                o_cmd.res_code  = i_sts.key_eq ? ST_FOUND : ST_NOT_FOUND;
            end
            S_SHIFT_ADDR: begin
                if (!i_sts.at_zero) begin
                    o_cmd.shift_rd = 1'b1;
                end else begin
                    o_cmd.place  = i_sts.out_free;
                    o_cmd.finish = i_sts.out_free;
                end
            end
            S_SHIFT_CMP: begin
                if (i_sts.rd_gt) begin
                    o_cmd.shift = 1'b1;
                end else begin
                    o_cmd.place  = i_sts.out_free;
                    o_cmd.finish = i_sts.out_free;
                end
            end
            S_PLACE: begin
                o_cmd.place  = i_sts.out_free;
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### design/stfs_dp.sv
// Datapath: record memories, Fibonacci registers, insert pointer and result register.
`timescale 1ns / 1ps
`default_nettype none

module stfs_dp import stfs_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  wire                  i_in_op,
    input  wire  [IN_W-1:0]      i_in_key,
    input  wire  [IN_W-1:0]      i_in_cost,
    input  wire                  i_out_ready,
    output logic                 o_out_valid,
    output logic [STATUS_W-1:0]  o_status,
    output logic [POS_W-1:0]     o_pos,
    output logic [KEY_W-1:0]     o_key,
    output logic [KEY_W-1:0]     o_cost,
    output logic [ENT_W-1:0]     o_entries
);

    // Record memories, kept in ascending key order
    logic [KEY_W-1:0] key_mem  [CAPACITY];
    logic [KEY_W-1:0] cost_mem [CAPACITY];

    // Item and search registers
    logic                    r_op;
    logic [IN_W-1:0]         r_key;
    logic [IN_W-1:0]         r_cost;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_at;
    logic [FIB_W-1:0]        r_f;
    logic [FIB_W-1:0]        r_f1;
    logic [FIB_W-1:0]        r_f2;
    logic signed [SUM_W-1:0] r_offset;
    logic [IDX_W-1:0]        r_hit_idx;
    logic [KEY_W-1:0]        r_rd_key;
    logic [KEY_W-1:0]        r_rd_cost;

    // Result register
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic [POS_W-1:0]        r_out_pos;
    logic [KEY_W-1:0]        r_out_key;
    logic [KEY_W-1:0]        r_out_cost;
    logic [ENT_W-1:0]        r_out_entries;

    logic [KEY_W-1:0]        key_t;
    logic signed [SUM_W-1:0] count_s;
    logic signed [SUM_W-1:0] probe_sum;
    logic signed [SUM_W-1:0] off_p1;
    logic [IDX_W-1:0]        last_idx;
    logic [IDX_W-1:0]        probe_idx;
    logic [CNT_W-1:0]        at_m1;
    logic [CNT_W-1:0]        at_m2;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [KEY_W-1:0]        wr_key;
    logic [KEY_W-1:0]        wr_cost;
    logic [CNT_W-1:0]        n_count;

    assign key_t    = r_key[KEY_W-1:0];
    assign count_s  = $signed({{(SUM_W-CNT_W){1'b0}}, r_count});
    assign last_idx = IDX_W'(r_count - 1'b1);
    assign at_m1    = r_at - 1'b1;
    assign at_m2    = r_at - 2'd2;
    assign n_count  = i_cmd.place ? r_count + 1'b1 : r_count;

    // Probe index: offset plus f2, clamped into the occupied range
    assign probe_sum = r_offset + $signed({1'b0, r_f2});
    assign off_p1    = r_offset + $signed(SUM_W'(1));
    always_comb begin
        priority if (probe_sum >= count_s) begin
            probe_idx = last_idx;
        end else if (probe_sum < 0) begin
            probe_idx = '0;
        end else begin
            probe_idx = probe_sum[IDX_W-1:0];
        end
    end

    // Status toward the controller
    always_comb begin
        o_sts.is_search = (r_op == OP_SEARCH);
        o_sts.full      = (r_count >= CNT_W'(CAPACITY));
        o_sts.key_bad   = r_key[IN_W-1] || (r_key == '0);
        o_sts.cost_neg  = r_cost[IN_W-1];
        o_sts.empty     = (r_count == '0);
        o_sts.fib_lt    = (r_f < {1'b0, r_count});
        o_sts.f_gt1     = (r_f > FIB_W'(1));
        o_sts.key_eq    = (r_rd_key == key_t);
        o_sts.key_lt    = (r_rd_key < key_t);
        o_sts.rd_gt     = (r_rd_key > key_t);
        o_sts.at_zero   = (r_at == '0);
        o_sts.at_one    = (r_at == CNT_W'(1));
        o_sts.final_ok  = (r_f1 == FIB_W'(1)) && (off_p1 < count_s);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    // Memory port selection
    always_comb begin
        rd_en   = i_cmd.probe_rd || i_cmd.final_rd || i_cmd.shift_rd ||
                  (i_cmd.shift && !o_sts.at_one);
        rd_addr = probe_idx;
        if (i_cmd.final_rd) rd_addr = off_p1[IDX_W-1:0];
        if (i_cmd.shift_rd) rd_addr = at_m1[IDX_W-1:0];
        if (i_cmd.shift)    rd_addr = at_m2[IDX_W-1:0];
        wr_en   = i_cmd.place || i_cmd.shift;
        wr_addr = r_at[IDX_W-1:0];
        wr_key  = i_cmd.place ? key_t : r_rd_key;
        wr_cost = i_cmd.place ? r_cost[KEY_W-1:0] : r_rd_cost;
    end

    // Record memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            key_mem[wr_addr]  <= wr_key;
            cost_mem[wr_addr] <= wr_cost;
        end
        if (rd_en) begin
            r_rd_key  <= key_mem[rd_addr];
            r_rd_cost <= cost_mem[rd_addr];
        end
    end

    // Control registers: record count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item, Fibonacci and insert pointer registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_in_op;
            r_key    <= i_in_key;
            r_cost   <= i_in_cost;
            r_at     <= r_count;
            r_f      <= FIB_W'(1);
            r_f1     <= FIB_W'(1);
            r_f2     <= '0;
            r_offset <= '1;
        end
        if (i_cmd.fib_step) begin
            r_f2 <= r_f1;
            r_f1 <= r_f;
            r_f  <= r_f + r_f1;
        end
        if (i_cmd.probe_rd) r_hit_idx <= probe_idx;
        if (i_cmd.final_rd) r_hit_idx <= off_p1[IDX_W-1:0];
        // Target above probe: drop one term, move offset to the probe
        if (i_cmd.probe_lt) begin
            r_f      <= r_f1;
            r_f1     <= r_f2;
            r_f2     <= r_f1 - r_f2;
            r_offset <= $signed({{(SUM_W-IDX_W){1'b0}}, r_hit_idx});
        end
        // Target below probe: drop two terms
        if (i_cmd.probe_gt) begin
            r_f  <= r_f2;
            r_f1 <= r_f1 - r_f2;
            r_f2 <= r_f2 + r_f2 - r_f1;
        end
        if (i_cmd.shift) r_at <= at_m1;
    end

    // Result register load
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status  <= i_cmd.res_code;
            r_out_entries <= ENT_W'(n_count);
            if (i_cmd.res_found) begin
                r_out_pos  <= POS_W'(r_hit_idx);
                r_out_key  <= r_rd_key;
                r_out_cost <= r_rd_cost;
            end else begin
                r_out_pos  <= '0;
                r_out_key  <= '0;
                r_out_cost <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_pos       = r_out_pos;
    assign o_key       = r_out_key;
    assign o_cost      = r_out_cost;
    assign o_entries   = r_out_entries;

endmodule

`default_nettype wire

### design/stfs_chk.sv
// Port-level checker for the sorted table search, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module stfs_chk import stfs_pkg::*; (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 s_axis_tvalid,
    input wire                 s_axis_tready,
    input wire [IN_DATA_W-1:0] s_axis_tdata,
    input wire                 s_axis_tuser,
    input wire                 m_axis_tvalid,
    input wire                 m_axis_tready,
    input wire [OUT_W-1:0]     m_axis_tdata
);

    logic [STATUS_W-1:0] out_status;
    assign out_status = m_axis_tdata[STATUS_W-1:0];

    // A stalled result transfer stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its data
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // One item at a time: input closes right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    // Status code and record count in range
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_status != 3'd7) &&
            (m_axis_tdata[OUT_W-1:OUT_W-ENT_W] <= ENT_W'(CAPACITY)))
        else $error("result status or count out of range");

    // Only a hit carries position, key and payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (out_status != ST_FOUND) |->
            (m_axis_tdata[OUT_W-ENT_W-1:STATUS_W] == '0))
        else $error("non-hit result carries record fields");

endmodule

bind sorted_table_fibonacci_search stfs_chk u_stfs_chk (.*);

`default_nettype wire

### verif/sorted_table_fibonacci_search_tb.sv
// Testbench for the sorted record table: random stream traffic, scoreboard against a table mirror.
`timescale 1ns / 1ps

module sorted_table_fibonacci_search_tb;
    import stfs_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int LONG_HOLD   = 1500;
    localparam int TAIL_CYCLES = 200;
    localparam int PRINT_MAX   = 40;

    // One input transfer and one expected result
    typedef struct {
        logic        op;
        logic [31:0] key;
        logic [31:0] cost;
    } t_op_item;

    typedef struct {
        t_status     status;
        logic [6:0]  pos;
        logic [30:0] key;
        logic [30:0] cost;
        logic [7:0]  held;
    } t_table_result;

    // Receiver stall patterns
    typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    wire                  s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;    // key_id[31:0], payload_cost[63:32]
    logic                 s_axis_tuser = 1'b0;  // operation
    wire                  m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    wire  [OUT_W-1:0]     m_axis_tdata;         // status, sorted_position, found_key,
                                                // found_cost, entries_held

    sorted_table_fibonacci_search uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mirror of the record table
    logic [30:0] mirror_key  [CAPACITY];
    logic [30:0] mirror_cost [CAPACITY];
    int          mirror_count = 0;

    t_op_item      op_queue[$];
    t_table_result result_queue[$];
    int            err_count = 0;
    int            cycle_count = 0;
    bit            hold_go = 1'b0;

    // Keys the generator expects to be stored, used to aim searches
    logic [31:0]   stored_keys[$];

    // Fibonacci search over the mirror; index of the hit or -1
    function automatic int fib_locate(input logic [30:0] target);
        int n;
        int f2, f1, f, offset, idx, guard;
        n = mirror_count;
        f2 = 0;
        f1 = 1;
        f = 1;
        offset = -1;
        while (f < n) begin
            f2 = f1;
            f1 = f;
            f = f1 + f2;
        end
        for (guard = 0; f > 1 && guard < 64; guard++) begin
            idx = offset + f2;
            if (idx >= n) idx = n - 1;
            if (idx < 0) idx = 0;
            if (mirror_key[idx] == target) return idx;
            if (mirror_key[idx] < target) begin
                f = f1;
                f1 = f2;
                f2 = f - f1;
                offset = idx;
            end else begin
                f = f2;
                f1 = f1 - f2;
                f2 = f - f1;
            end
        end
        if (f1 == 1 && offset + 1 >= 0 && offset + 1 < n &&
            mirror_key[offset + 1] == target)
            return offset + 1;
        return -1;
    endfunction

    // Applies one transfer to the mirror and returns the result it must produce
    function automatic t_table_result apply_table_op(input t_op_item it);
        t_table_result r;
        bit            key_ok;
        int            at, hit;
        r.status = ST_NOT_FOUND;
        r.pos = '0;
        r.key = '0;
        r.cost = '0;
        key_ok = !it.key[31] && it.key != 0;
        if (it.op == OP_INSERT) begin
            if (mirror_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else if (!key_ok) begin
                r.status = ST_BAD_KEY;
            end else if (it.cost[31]) begin
                r.status = ST_BAD_COST;
            end else begin
                // equal keys stay in arrival order
                at = mirror_count;
                while (at > 0 && mirror_key[at-1] > it.key[30:0]) begin
                    mirror_key[at] = mirror_key[at-1];
                    mirror_cost[at] = mirror_cost[at-1];
                    at--;
                end
                mirror_key[at] = it.key[30:0];
                mirror_cost[at] = it.cost[30:0];
                mirror_count++;
                r.status = ST_INSERTED;
            end
        end else begin
            if (!key_ok) begin
                r.status = ST_BAD_KEY;
            end else if (mirror_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                hit = fib_locate(it.key[30:0]);
                if (hit >= 0) begin
                    r.status = ST_FOUND;
                    r.pos = hit[6:0];
                    r.key = mirror_key[hit];
                    r.cost = mirror_cost[hit];
                end
            end
        end
        r.held = mirror_count[7:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < PRINT_MAX)
            $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // Queues one transfer and tracks which inserts will be taken
    task automatic push_op(input logic op, input logic [31:0] key, input logic [31:0] cost);
        t_op_item it;
        it.op = op;
        it.key = key;
        it.cost = cost;
        if (op == OP_INSERT && stored_keys.size() < CAPACITY && !key[31] && key != 0 &&
            !cost[31])
            stored_keys.push_back(key);
        op_queue.push_back(it);
    endtask

    function automatic logic [31:0] rand_pos_key();
        logic [31:0] k;
        case ($urandom_range(9))
            0, 1, 2, 3: k = $urandom_range(1, 64);             // dense range, many duplicates
            4:          k = $urandom_range(0, 3) == 0 ? 32'd1 : 32'h7FFF_FFFF - $urandom_range(2);
            default:    k = $urandom_range(32'h7FFF_FFFF, 1);
        endcase
        if (k == 0) k = 1;
        return k;
    endfunction

    function automatic logic [31:0] rand_bad_key();
        case ($urandom_range(2))
            0:       return 32'd0;
            1:       return 32'h8000_0000;
            default: return {1'b1, 31'($urandom)};
        endcase
    endfunction

    // Random phase: searches mostly aimed at stored keys, inserts mostly well formed
    task automatic queue_random(input int count);
        logic [31:0] k, c;
        int          pick;
        repeat (count) begin
            c = $urandom_range(19) == 0 ? {1'b1, 31'($urandom)} : {1'b0, 31'($urandom)};
            if ($urandom_range(99) < 25) begin
                k = $urandom_range(19) == 0 ? rand_bad_key() : rand_pos_key();
                push_op(OP_INSERT, k, c);
            end else begin
                pick = $urandom_range(99);
                if (pick < 60 && stored_keys.size() > 0) begin
                    k = stored_keys[$urandom_range(stored_keys.size() - 1)];
                end else if (pick < 75 && stored_keys.size() > 0) begin
                    k = stored_keys[$urandom_range(stored_keys.size() - 1)];
                    k = $urandom_range(1) ? k + 1 : k - 1;
                    if (k == 0 || k[31]) k = 32'd2;
                end else if (pick < 90) begin
                    k = rand_pos_key();
                end else begin
                    k = rand_bad_key();
                end
                push_op(OP_SEARCH, k, {$urandom});
            end
        end
    endtask

    task automatic wait_drained();
        while (op_queue.size() != 0 || s_axis_tvalid || result_queue.size() != 0)
            @(posedge i_clk);
    endtask

    // Driver: bursts of transfers separated by random gaps
    int       burst_left = 1;
    int       gap_left = 0;
    t_op_item cur_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                result_queue.push_back(apply_table_op(cur_item));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    cur_item = op_queue.pop_front();
                    s_axis_tdata <= {cur_item.cost, cur_item.key};
                    s_axis_tuser <= cur_item.op;
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 15);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: changing stall patterns plus one long hold-off
    t_rx_mode rx_mode = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    logic     rx_ready;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_go && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rx_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(3));
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:     rx_ready = 1'b1;
                    RX_HALF:     rx_ready = 1'($urandom_range(1));
                    RX_SPARSE:   rx_ready = $urandom_range(5) == 0;
                    default:     rx_ready = (cycle_count % 5) != 0;
                endcase
            end
            m_axis_tready <= rx_ready;
        end
    end

    // Result check against the oldest expectation
    t_table_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_queue.size() == 0) begin
                report_mismatch("unexpected result", 32'(m_axis_tdata[2:0]), 32'd0);
            end else begin
                want = result_queue.pop_front();
                if (m_axis_tdata[2:0] !== want.status)
                    report_mismatch("status", 32'(m_axis_tdata[2:0]), 32'(want.status));
                if (m_axis_tdata[9:3] !== want.pos)
                    report_mismatch("sorted_position", 32'(m_axis_tdata[9:3]), 32'(want.pos));
                if (m_axis_tdata[40:10] !== want.key)
                    report_mismatch("found_key", 32'(m_axis_tdata[40:10]), 32'(want.key));
                if (m_axis_tdata[71:41] !== want.cost)
                    report_mismatch("found_cost", 32'(m_axis_tdata[71:41]), 32'(want.cost));
                if (m_axis_tdata[79:72] !== want.held)
                    report_mismatch("entries_held", 32'(m_axis_tdata[79:72]), 32'(want.held));
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: refusals, empty table, extremes, duplicates
        push_op(OP_SEARCH, 32'd5, 32'd0);                  // empty table
        push_op(OP_SEARCH, 32'd0, 32'd0);                  // bad key wins over empty
        push_op(OP_SEARCH, 32'h8000_0000, 32'hFFFF_FFFF);
        push_op(OP_INSERT, 32'd0, 32'd1);
        push_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // key checked before payload
        push_op(OP_INSERT, 32'd10, 32'h8000_0000);
        push_op(OP_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_op(OP_SEARCH, 32'h7FFF_FFFF, 32'd0);
        push_op(OP_INSERT, 32'd1, 32'd0);
        push_op(OP_INSERT, 32'd1000, 32'd5);
        push_op(OP_INSERT, 32'd1000, 32'd6);
        push_op(OP_INSERT, 32'd1000, 32'd7);
        push_op(OP_SEARCH, 32'd1, 32'd0);
        push_op(OP_SEARCH, 32'd1000, 32'd0);
        push_op(OP_SEARCH, 32'd999, 32'd0);
        push_op(OP_SEARCH, 32'h7FFF_FFFE, 32'd0);
        push_op(OP_SEARCH, 32'd2, 32'hFFFF_FFFF);          // payload ignored on search
        push_op(OP_INSERT, 32'd500, 32'h7FFF_FFFF);
        push_op(OP_SEARCH, 32'd500, 32'd0);
        push_op(OP_SEARCH, 32'hFFFF_FFFB, 32'd0);
        push_op(OP_INSERT, 32'd2, 32'd123);
        push_op(OP_SEARCH, 32'd2, 32'd0);
        wait_drained();

        // Growing table; long receiver hold-off while the sender keeps going
        queue_random(800);
        while (op_queue.size() > 650) @(posedge i_clk);
        hold_go <= 1'b1;
        wait_drained();

        // Full table: inserts refused, searches over all 128 records
        queue_random(830);
        while (op_queue.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (result_queue.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
